/* rtl/sliding_window_event_rate_meter_unit_assert.svh */
// assertion macros for the event rate meter
`ifndef SLIDING_WINDOW_EVENT_RATE_METER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_RATE_METER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SWERM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWERM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWERM_ASSERT(lbl, clk, rstn, prop, msg)
`define SWERM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/swerm_pkg.sv */
`default_nettype none
package swerm_pkg;

    localparam int DEPTH        = 128;
    localparam int NCHAN        = 3;
    localparam int TW           = 32;
    localparam int WINW         = 16;
    localparam int RW           = 25;
    localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int MS_PER_S     = 1000;
    localparam int RATE_SCALE   = MS_PER_S * 256;
    localparam int NW           = CW + 18;
    localparam int QW           = (NW > RW) ? NW : RW;
    localparam int SW           = $clog2(NW + 1);
    localparam int RATE_MAX     = (1 << RW) - 1;

    localparam logic [WINW-1:0] WINDOW_RESET = WINW'(1000);

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PREP,
        S_DSTART,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          wr_en;
        logic          start;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          prep;
        logic          div_start;
        logic          load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* rtl/swerm_div.sv */
`default_nettype none
module swerm_div import swerm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [TW-1:0] i_den,
    output logic      [NW-1:0] o_quo,
    output logic               o_busy
);

    logic          r_busy;
    logic [SW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_den;
    logic [TW:0]   w_trial;
    logic [TW:0]   w_diff;
    logic          w_ge;

    // restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SW'(NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != SW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[TW-1:0] : w_trial[TW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

/* rtl/swerm_ring.sv */
`default_nettype none
`include "sliding_window_event_rate_meter_unit_assert.svh"
module swerm_ring import swerm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [TW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_start,
    input  wire logic [TW-1:0] i_start_now,
    input  wire logic [TW-1:0] i_threshold,
    output logic      [CW-1:0] o_count,
    output logic      [TW-1:0] o_earliest
);

    logic [TW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr_pos;
    logic [CW-1:0] r_fill;
    logic [TW-1:0] r_rd_data;
    logic          r_rd_ok;
    logic          r_acc_en;
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_earliest;
    logic [TW-1:0] w_t;
    logic          w_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_pos] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_ok   <= CW'(i_rd_addr) < r_fill;
        end
    end

    // entries at or above the fill count are read as zero; the memory itself is never cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_fill   <= '0;
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_rd_en;
            if (i_wr_en) begin
                r_wr_pos <= (r_wr_pos == AW'(DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
                if (r_fill != CW'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    assign w_t   = r_rd_ok ? r_rd_data : '0;
    assign w_hit = w_t >= i_threshold;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_count    <= '0;
            r_earliest <= i_start_now;
        end else if (r_acc_en && w_hit) begin
            r_count <= r_count + 1'b1;
            if (w_t < r_earliest) begin
                r_earliest <= w_t;
            end
        end
    end

    assign o_count    = r_count;
    assign o_earliest = r_earliest;

    `SWERM_ASSERT(a_fill_after_write, i_clk, i_rst_n, i_wr_en |=> (r_fill != '0), "fill count still zero after a write")

endmodule
`default_nettype wire

/* rtl/swerm_datapath.sv */
`default_nettype none
`include "sliding_window_event_rate_meter_unit_assert.svh"
module swerm_datapath import swerm_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_ctl,
    output t_status              o_sts,
    input  wire logic [1:0]      i_channel,
    input  wire logic [TW-1:0]   i_now_ms,
    input  wire logic            i_cfg_we,
    input  wire logic [WINW-1:0] i_cfg_wdata,
    input  wire logic            i_out_stall,
    output logic                 o_out_valid,
    output logic      [RW-1:0]   o_rate_emulated,
    output logic      [RW-1:0]   o_rate_drawn,
    output logic      [RW-1:0]   o_rate_blitted,
    output logic                 o_valid_emulated,
    output logic                 o_valid_drawn,
    output logic                 o_valid_blitted
);

    logic [WINW-1:0] r_window;
    logic [TW-1:0]   r_now;
    logic [TW-1:0]   r_thr;
    logic            r_out_valid;
    logic [RW-1:0]   r_rate [NCHAN];
    logic            r_ok_out [NCHAN];
    logic [NW-1:0]   r_num [NCHAN];
    logic [TW-1:0]   r_den [NCHAN];
    logic            r_ok [NCHAN];
    logic [CW-1:0]   w_count [NCHAN];
    logic [TW-1:0]   w_earliest [NCHAN];
    logic [NW-1:0]   w_quo [NCHAN];
    logic [NCHAN-1:0] w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_now <= i_now_ms;
            r_thr <= i_now_ms - TW'(r_window);
        end
    end

    for (genvar g = 0; g < NCHAN; g++) begin : g_chan
        swerm_ring u_ring (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (i_ctl.wr_en && (i_channel == 2'(g))),
            .i_wr_data   (i_now_ms),
            .i_rd_en     (i_ctl.rd_en),
            .i_rd_addr   (i_ctl.rd_addr),
            .i_start     (i_ctl.start),
            .i_start_now (i_now_ms),
            .i_threshold (r_thr),
            .o_count     (w_count[g]),
            .o_earliest  (w_earliest[g])
        );

        always_ff @(posedge i_clk) begin
            if (i_ctl.prep) begin
                r_num[g] <= NW'(w_count[g]) * NW'(RATE_SCALE);
                r_den[g] <= r_now - w_earliest[g];
                r_ok[g]  <= (r_now != w_earliest[g]);
            end
        end

        swerm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_ctl.div_start),
            .i_num   (r_num[g]),
            .i_den   (r_den[g]),
            .o_quo   (w_quo[g]),
            .o_busy  (w_busy[g])
        );

        // zero span gives no rate, an oversized quotient saturates
        always_ff @(posedge i_clk) begin
            if (i_ctl.load_out) begin
                r_ok_out[g] <= r_ok[g];
                if (!r_ok[g]) begin
                    r_rate[g] <= '0;
                end else if (QW'(w_quo[g]) > QW'(RATE_MAX)) begin
                    r_rate[g] <= RW'(RATE_MAX);
                end else begin
                    r_rate[g] <= RW'(w_quo[g]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_done = ~|w_busy;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_rate_emulated  = r_rate[0];
    assign o_rate_drawn     = r_rate[1];
    assign o_rate_blitted   = r_rate[2];
    assign o_valid_emulated = r_ok_out[0];
    assign o_valid_drawn    = r_ok_out[1];
    assign o_valid_blitted  = r_ok_out[2];

    `SWERM_ASSERT(a_load_shows, i_clk, i_rst_n, i_ctl.load_out |=> r_out_valid, "result not shown after load")

endmodule
`default_nettype wire

/* rtl/swerm_ctrl.sv */
`default_nettype none
`include "sliding_window_event_rate_meter_unit_assert.svh"
module swerm_ctrl import swerm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_cmd,
    output logic         o_in_stall,
    input  wire t_status i_sts,
    output t_cmd         o_ctl
);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic          w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        o_ctl         = '0;
        o_ctl.rd_addr = r_addr;
        case (r_state)
            S_IDLE: begin
                n_addr = '0;
                if (w_accept) begin
                    if (i_cmd == CMD_QUERY) begin
                        o_ctl.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_ctl.wr_en = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_ctl.rd_en = 1'b1;
                n_addr      = r_addr + 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                o_ctl.prep = 1'b1;
                n_state    = S_DSTART;
            end
            S_DSTART: begin
                o_ctl.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `SWERM_ASSERT(a_query_scans, i_clk, i_rst_n, (w_accept && (i_cmd == CMD_QUERY)) |=> (r_state == S_SCAN), "query did not start a scan")
    `SWERM_ASSERT(a_div_runs, i_clk, i_rst_n, o_ctl.div_start |=> !i_sts.div_done, "dividers idle after start")
    `SWERM_ASSERT(a_scan_from_zero, i_clk, i_rst_n, (r_state == S_IDLE) |=> ((r_state != S_SCAN) || (r_addr == '0)), "scan did not begin at entry zero")

endmodule
`default_nettype wire

/* rtl/sliding_window_event_rate_meter_unit.sv */
`default_nettype none
// channel  handshake                 payload
// input    i_in_valid / o_in_stall   i_cmd i_channel i_now_ms
// output   o_out_valid / i_out_stall o_rate_* o_valid_*
// config   i_cfg_we                  i_cfg_wdata (window_ms)
// an event is written at its transfer, leaving the block ready; a query runs the ring scan,
// drain, prep, divider start, division and output load before the next transfer, its time
// set by the ring scan at one entry per cycle and the restoring dividers at one bit per cycle
// reset is synchronous, active low; ring entries read as zero until written through a
// fill count, so there is no clearing pass
// the output register holds a result while stalled and events are taken meanwhile;
// a finished query waits until the output register is free
module sliding_window_event_rate_meter_unit import swerm_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_cmd,
    input  wire logic [1:0]      i_channel,
    input  wire logic [TW-1:0]   i_now_ms,
    input  wire logic            i_cfg_we,
    input  wire logic [WINW-1:0] i_cfg_wdata,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic      [RW-1:0]   o_rate_emulated,
    output logic      [RW-1:0]   o_rate_drawn,
    output logic      [RW-1:0]   o_rate_blitted,
    output logic                 o_valid_emulated,
    output logic                 o_valid_drawn,
    output logic                 o_valid_blitted
);

    t_cmd    w_ctl;
    t_status w_sts;

    swerm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    swerm_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_channel        (i_channel),
        .i_now_ms         (i_now_ms),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_rate_emulated  (o_rate_emulated),
        .o_rate_drawn     (o_rate_drawn),
        .o_rate_blitted   (o_rate_blitted),
        .o_valid_emulated (o_valid_emulated),
        .o_valid_drawn    (o_valid_drawn),
        .o_valid_blitted  (o_valid_blitted)
    );

endmodule
`default_nettype wire

/* test/rate_meter_checker.sv */
`timescale 1ns / 100ps

module rate_meter_checker import swerm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  logic            i_cmd,
    input  logic [1:0]      i_channel,
    input  logic [TW-1:0]   i_now_ms,
    input  logic            i_cfg_we,
    input  logic [WINW-1:0] i_cfg_wdata,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  logic [RW-1:0]   i_rate_emulated,
    input  logic [RW-1:0]   i_rate_drawn,
    input  logic [RW-1:0]   i_rate_blitted,
    input  logic            i_valid_emulated,
    input  logic            i_valid_drawn,
    input  logic            i_valid_blitted,
    output int              o_mismatches,
    output int              o_pending
);

    typedef struct packed {
        logic [NCHAN-1:0][RW-1:0] rate;
        logic [NCHAN-1:0]         valid;
    } t_reading;

    logic [TW-1:0]   stamps [NCHAN][DEPTH];
    int unsigned     wr_pos [NCHAN];
    logic [WINW-1:0] window_ms;
    t_reading        readings [$];

    logic [NCHAN-1:0][RW-1:0] seen_rate;
    logic [NCHAN-1:0]         seen_valid;

    assign seen_rate  = {i_rate_blitted, i_rate_drawn, i_rate_emulated};
    assign seen_valid = {i_valid_blitted, i_valid_drawn, i_valid_emulated};

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_mismatches < 40) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        t_reading      want;
        logic [TW-1:0] threshold;
        logic [TW-1:0] earliest;
        logic [TW-1:0] span;
        logic [63:0]   count;
        logic [63:0]   quotient;
        if (!i_rst_n) begin
            for (int c = 0; c < NCHAN; c++) begin
                wr_pos[c] = 0;
                for (int i = 0; i < DEPTH; i++) stamps[c][i] = '0;
            end
            window_ms = WINDOW_RESET;
            readings.delete();
        end else begin
            // result transfer
            if (i_out_valid && !i_out_stall) begin
                if (readings.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, '0);
                end else begin
                    want = readings.pop_front();
                    for (int c = 0; c < NCHAN; c++) begin
                        if (seen_rate[c] !== want.rate[c])
                            report_mismatch($sformatf("rate of channel %0d", c),
                                            32'(seen_rate[c]), 32'(want.rate[c]));
                        if (seen_valid[c] !== want.valid[c])
                            report_mismatch($sformatf("valid of channel %0d", c),
                                            32'(seen_valid[c]), 32'(want.valid[c]));
                    end
                end
            end

            // input transfer
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == CMD_RECORD) begin
                    if (i_channel < NCHAN) begin
                        stamps[i_channel][wr_pos[i_channel]] = i_now_ms;
                        wr_pos[i_channel] = (wr_pos[i_channel] + 1) % DEPTH;
                    end
                end else begin
                    threshold = i_now_ms - TW'(window_ms);
                    for (int c = 0; c < NCHAN; c++) begin
                        earliest = i_now_ms;
                        count    = '0;
                        for (int i = 0; i < DEPTH; i++) begin
                            if (stamps[c][i] >= threshold) begin
                                if (stamps[c][i] < earliest) earliest = stamps[c][i];
                                count++;
                            end
                        end
                        span = i_now_ms - earliest;
                        if (span == '0) begin
                            want.rate[c]  = '0;
                            want.valid[c] = 1'b0;
                        end else begin
                            quotient = (count * 64'(RATE_SCALE)) / 64'(span);
                            if (quotient > 64'(RATE_MAX)) quotient = 64'(RATE_MAX);
                            want.rate[c]  = quotient[RW-1:0];
                            want.valid[c] = 1'b1;
                        end
                    end
                    readings.push_back(want);
                end
            end

            // the window register takes its new value at the end of this cycle
            if (i_cfg_we) window_ms = i_cfg_wdata;
        end
        o_pending <= readings.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import swerm_pkg::*;

    localparam int QUERY_CYCLES = DEPTH + NW + 5;
    localparam int HOLD_CYCLES  = 800;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    logic            cmd       = CMD_RECORD;
    logic [1:0]      channel   = 2'd0;
    logic [TW-1:0]   now_ms    = '0;
    logic            cfg_we    = 1'b0;
    logic [WINW-1:0] cfg_wdata = WINDOW_RESET;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [RW-1:0]   rate_emulated;
    logic [RW-1:0]   rate_drawn;
    logic [RW-1:0]   rate_blitted;
    logic            valid_emulated;
    logic            valid_drawn;
    logic            valid_blitted;
    int              mismatch_count;
    int              results_owed;

    logic calm         = 1'b0;
    logic hold_request = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_event_rate_meter_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_channel        (channel),
        .i_now_ms         (now_ms),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_rate_emulated  (rate_emulated),
        .o_rate_drawn     (rate_drawn),
        .o_rate_blitted   (rate_blitted),
        .o_valid_emulated (valid_emulated),
        .o_valid_drawn    (valid_drawn),
        .o_valid_blitted  (valid_blitted)
    );

    rate_meter_checker meter_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_channel        (channel),
        .i_now_ms         (now_ms),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_rate_emulated  (rate_emulated),
        .i_rate_drawn     (rate_drawn),
        .i_rate_blitted   (rate_blitted),
        .i_valid_emulated (valid_emulated),
        .i_valid_drawn    (valid_drawn),
        .i_valid_blitted  (valid_blitted),
        .o_mismatches     (mismatch_count),
        .o_pending        (results_owed)
    );

    task automatic send_item(input logic c, input logic [1:0] ch, input logic [TW-1:0] t);
        if (!calm && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        channel  <= ch;
        now_ms   <= t;
        do @(posedge clk); while (in_stall);
    endtask

    // waits for the block to go quiet, then writes the window length
    task automatic set_window(input logic [WINW-1:0] w);
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (QUERY_CYCLES) @(posedge clk);
        cfg_wdata <= w;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // events at frame-like steps on a running clock, queries mostly at the current time and some in
    // the past, with some noise and ignored events mixed in
    task automatic run_phase(input int n_items, input int step_max, input logic [TW-1:0] start_ms);
        int            sent;
        int            roll;
        logic [TW-1:0] clock_ms;
        sent     = 0;
        clock_ms = start_ms;
        while (sent < n_items) begin
            roll     = $urandom_range(0, 99);
            clock_ms = clock_ms + TW'($urandom_range(0, step_max));
            if (roll < 4) begin
                send_item(1'($urandom), 2'($urandom), TW'($urandom));
                sent++;
            end else if (roll < 7) begin
                send_item(CMD_RECORD, 2'd3, clock_ms);
            end else if (roll < 10) begin
                send_item(CMD_QUERY, 2'($urandom),
                          clock_ms - TW'($urandom_range(0, 4 * step_max)));
                sent++;
            end else if (roll < 36) begin
                send_item(CMD_QUERY, 2'($urandom), clock_ms);
                sent++;
            end else begin
                send_item(CMD_RECORD, 2'($urandom_range(0, 2)), clock_ms);
                sent++;
            end
        end
    endtask

    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < 9);
            end
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty rings, then all reset entries inside the window
        send_item(CMD_QUERY, 2'd0, 32'd0);
        send_item(CMD_QUERY, 2'd3, 32'd1000);
        send_item(CMD_RECORD, 2'd0, 32'd100);
        send_item(CMD_RECORD, 2'd0, 32'd200);
        send_item(CMD_RECORD, 2'd0, 32'd300);
        send_item(CMD_RECORD, 2'd1, 32'd500);
        send_item(CMD_RECORD, 2'd2, 32'd999);
        send_item(CMD_RECORD, 2'd3, 32'd400);
        send_item(CMD_QUERY, 2'd1, 32'd1200);
        send_item(CMD_QUERY, 2'd2, 32'd300);
        // time wrapping through zero
        send_item(CMD_RECORD, 2'd0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 2'd0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 2'd0, 32'd0);
        send_item(CMD_RECORD, 2'd1, 32'h8000_0000);
        send_item(CMD_RECORD, 2'd2, 32'h7FFF_FFFF);
        send_item(CMD_QUERY, 2'd2, 32'h8000_0100);
        send_item(CMD_RECORD, 2'd1, 32'h8000_0200);
        send_item(CMD_QUERY, 2'd1, 32'h8000_0200);
        send_item(CMD_QUERY, 2'd3, 32'h8000_03E8);

        run_phase(230, 20, TW'($urandom));

        set_window(16'd1);
        run_phase(230, 2, 32'hFFFF_FED4);

        set_window(16'hFFFF);
        hold_request = 1'b1;
        run_phase(230, 60, TW'($urandom));

        set_window(16'd0);
        run_phase(150, 10, TW'($urandom));

        set_window(WINW'($urandom_range(2, 65534)));
        calm = 1'b1;
        run_phase(230, 40, TW'($urandom));
        calm = 1'b0;

        set_window(WINDOW_RESET);
        run_phase(230, 30, 32'hFFFF_FF00);

        set_window(16'd250);
        run_phase(260, 20, 32'd0);

        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (2 * QUERY_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
